@@ hdl/csvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types and character codes for the CSV field and record splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int unsigned MAX_EVENTS = 3;

    typedef enum logic [6:0] {
        PH_REC_START   = 7'b0000001,
        PH_FIELD_START = 7'b0000010,
        PH_UNQUOTED    = 7'b0000100,
        PH_QUOTED      = 7'b0001000,
        PH_QUOTE_SEEN  = 7'b0010000,
        PH_CR_SEEN     = 7'b0100000,
        PH_ERROR       = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        EV_CONTENT    = 2'd0,
        EV_FIELD_END  = 2'd1,
        EV_RECORD_END = 2'd2,
        EV_ERROR      = 2'd3
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [7:0]  data;
    } event_t;

    typedef struct packed {
        logic [1:0]                   count;
        event_t [MAX_EVENTS-1:0]      ev;
    } bundle_t;

endpackage

@@ hdl/csvs_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs_step
// Parse one text byte against the current phase; produce up to three events
// and the next phase.
// ----------------------------------------------------------------------------
module csvs_step
    import csvs_pkg::*;
(
    input  phase_t      phase,
    input  logic [7:0]  text_byte,
    input  logic        end_of_input,
    output bundle_t     bundle,
    output phase_t      phase_next
);

    logic   err;
    logic   idle;
    phase_t ph;

    always_comb
    begin
        bundle = '0;
        err    = 1'b0;
        idle   = 1'b0;
        ph     = phase;
        case (phase)
            PH_REC_START, PH_FIELD_START, PH_UNQUOTED:
            begin
                if (text_byte == CH_QUOTE)
                begin
                    if (phase == PH_UNQUOTED)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        ph = PH_QUOTED;
                    end
                end
                else if (text_byte == CH_COMMA)
                begin
                    bundle.ev[0].kind = EV_FIELD_END;
                    bundle.count      = 2'd1;
                    ph                = PH_FIELD_START;
                end
                else if (text_byte == CH_CR)
                begin
                    ph = PH_CR_SEEN;
                end
                else if (text_byte == CH_LF)
                begin
                    bundle.ev[0].kind = EV_FIELD_END;
                    bundle.ev[1].kind = EV_RECORD_END;
                    bundle.count      = 2'd2;
                    ph                = PH_REC_START;
                end
                else
                begin
                    bundle.ev[0].kind = EV_CONTENT;
                    bundle.ev[0].data = text_byte;
                    bundle.count      = 2'd1;
                    ph                = PH_UNQUOTED;
                end
            end
            PH_QUOTED:
            begin
                if (text_byte == CH_QUOTE)
                begin
                    ph = PH_QUOTE_SEEN;
                end
                else
                begin
                    bundle.ev[0].kind = EV_CONTENT;
                    bundle.ev[0].data = text_byte;
                    bundle.count      = 2'd1;
                end
            end
            PH_QUOTE_SEEN:
            begin
                if (text_byte == CH_QUOTE)
                begin
                    bundle.ev[0].kind = EV_CONTENT;
                    bundle.ev[0].data = CH_QUOTE;
                    bundle.count      = 2'd1;
                    ph                = PH_QUOTED;
                end
                else if (text_byte == CH_COMMA)
                begin
                    bundle.ev[0].kind = EV_FIELD_END;
                    bundle.count      = 2'd1;
                    ph                = PH_FIELD_START;
                end
                else if (text_byte == CH_CR)
                begin
                    ph = PH_CR_SEEN;
                end
                else if (text_byte == CH_LF)
                begin
                    bundle.ev[0].kind = EV_FIELD_END;
                    bundle.ev[1].kind = EV_RECORD_END;
                    bundle.count      = 2'd2;
                    ph                = PH_REC_START;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            PH_CR_SEEN:
            begin
                if (text_byte == CH_LF)
                begin
                    bundle.ev[0].kind = EV_FIELD_END;
                    bundle.ev[1].kind = EV_RECORD_END;
                    bundle.count      = 2'd2;
                    ph                = PH_REC_START;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            default:
            begin
                idle = 1'b1;
            end
        endcase

        // close the open field and record at the end of the text
        if (!idle && !err && end_of_input)
        begin
            if (ph inside {PH_FIELD_START, PH_UNQUOTED, PH_QUOTE_SEEN})
            begin
                if (bundle.count == 2'd0)
                begin
                    bundle.ev[0].kind = EV_FIELD_END;
                    bundle.ev[1].kind = EV_RECORD_END;
                    bundle.count      = 2'd2;
                end
                else
                begin
                    bundle.ev[1].kind = EV_FIELD_END;
                    bundle.ev[2].kind = EV_RECORD_END;
                    bundle.count      = 2'd3;
                end
            end
            else if (ph inside {PH_QUOTED, PH_CR_SEEN})
            begin
                err = 1'b1;
            end
        end

        if (err)
        begin
            bundle            = '0;
            bundle.ev[0].kind = EV_ERROR;
            bundle.count      = 2'd1;
            ph                = PH_ERROR;
        end

        if (end_of_input)
        begin
            ph = PH_REC_START;
        end
        phase_next = ph;
    end

endmodule

@@ hdl/csv_field_record_splitter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_record_splitter_core
// Streaming CSV splitter: text bytes in, content, field-end, record-end and
// error events out.
// ----------------------------------------------------------------------------
// A text byte enters an input register and is parsed from there once the
// result register is empty or giving out its last event; its events (zero to
// three) land together in the result register, which hands out one event per
// cycle while out_ready is high. The next byte waits in the input register
// until the single result register has drained every event of the byte
// before. run_last marks the final event of each byte; bytes that give no
// event produce no output.
module csv_field_record_splitter_core
    import csvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [7:0]  content_byte,
    output logic        run_last
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    bundle_t     step_bundle;
    bundle_t     bundle_reg;
    logic        out_valid_reg;
    logic [1:0]  pos_reg;

    logic        pos_last;
    logic        drain;
    logic        advance;
    logic        load;
    event_t      cur_event;

    csvs_step u_step
    (
        .phase        (phase_reg),
        .text_byte    (byte_reg),
        .end_of_input (last_reg),
        .bundle       (step_bundle),
        .phase_next   (phase_next)
    );

    assign pos_last  = (pos_reg == (bundle_reg.count - 2'd1));
    assign drain     = out_valid_reg && out_ready && pos_last;
    assign advance   = in_valid_reg && (!out_valid_reg || drain);
    assign load      = advance && (step_bundle.count != 2'd0);
    assign in_ready  = !in_valid_reg || advance;

    assign cur_event    = bundle_reg.ev[pos_reg];
    assign out_valid    = out_valid_reg;
    assign event_kind   = cur_event.kind;
    assign content_byte = cur_event.data;
    assign run_last     = pos_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_REC_START;
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= 2'd0;
            end
            else if (drain)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
            last_reg <= end_of_input;
        end
        if (load)
        begin
            bundle_reg <= step_bundle;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pos_reg < bundle_reg.count))
        else $error("result position beyond bundle count");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (event_kind == EV_ERROR)) |-> (run_last && (pos_reg == 2'd0)))
        else $error("error event not reported alone");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg))
        else $error("phase changed without a parsed request");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (phase_reg == PH_REC_START))
        else $error("phase not back at record start after final byte");

endmodule
